### rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// shared types, codes and helpers of the alphabet rank bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  localparam int ALPHABET_MAX_DEF = 128;
  localparam int PAD_BITS         = 3;
  localparam int BYTE_BITS        = 8;
  localparam int MAP_SIZE         = 256;
  localparam int GROUPS           = 16;
  localparam int GROUP_SIZE       = MAP_SIZE / GROUPS;
  localparam int GCNT_W           = $clog2(GROUP_SIZE + 1);
  localparam int LEN_W            = 24;

  localparam logic [2:0] ACT_COLLECT = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_ENCODE  = 3'd2;
  localparam logic [2:0] ACT_FLUSH   = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_ENCODE,
    KIND_MISS,
    KIND_FLUSH
  } arp_kind_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
  } arp_in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [7:0] distinct_count;
    logic [2:0] code_width;
    logic       not_found;
    logic       is_status;
  } arp_out_t;

  // work item between front and back
  typedef struct packed {
    arp_kind_t                      kind;
    logic [2:0]                     width;
    logic [2:0]                     pad;
    logic [7:0]                     distinct;
    logic [GROUPS-1:0][GCNT_W-1:0]  gcnt;
  } arp_work_t;

  function automatic logic [2:0] width_for(input logic [7:0] count);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if ((9'd1 << i) < {1'b0, count}) begin
        n = 3'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [GCNT_W-1:0] popcount_group(input logic [GROUP_SIZE-1:0] v);
    logic [GCNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      c = c + GCNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/arp_front.sv
// ----------------------------------------------------------------------------
// arp_front
// accepts items, keeps the seen map and the latched width, classifies items
// and computes per-group rank counts for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_front #(
  parameter int ALPHABET_MAX = arp_pkg::ALPHABET_MAX_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   acc,
  input  arp_pkg::arp_in_t      in_item,
  input  wire                   cfg_we,
  input  wire [arp_pkg::LEN_W-1:0] cfg_data,
  output logic                  wr_en,
  output arp_pkg::arp_work_t    wr_data
);
  import arp_pkg::*;

  logic [MAP_SIZE-1:0] seen_r, seen_nxt;
  logic [7:0]          distinct_r, distinct_nxt;
  logic                active_r, active_nxt;
  logic [2:0]          width_r, width_nxt;
  logic [2:0]          pad_r, pad_nxt;
  logic [2:0]          len_lo_r;
  logic [MAP_SIZE-1:0] below;
  logic [MAP_SIZE-1:0] masked;
  logic [5:0]          len_prod;
  logic [2:0]          total_lo;
  logic                hit;

  // only the low three length bits reach the pad count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_lo_r <= '0;
    end else if (cfg_we) begin
      len_lo_r <= cfg_data[2:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAP_SIZE; i++) begin
      below[i] = (8'(i) < in_item.data_byte);
    end
    masked = seen_r & below;
    hit    = seen_r[in_item.data_byte];
  end

  always_comb begin
    seen_nxt     = seen_r;
    distinct_nxt = distinct_r;
    active_nxt   = active_r;
    width_nxt    = width_r;
    pad_nxt      = pad_r;
    wr_en        = 1'b0;
    len_prod     = 6'({3'b000, len_lo_r} * {3'b000, width_for(distinct_r)});
    total_lo     = 3'(PAD_BITS) + len_prod[2:0];

    wr_data.kind     = KIND_ENCODE;
    wr_data.width    = width_r;
    wr_data.pad      = pad_r;
    wr_data.distinct = distinct_r;
    for (int g = 0; g < GROUPS; g++) begin
      wr_data.gcnt[g] = popcount_group(masked[g*GROUP_SIZE +: GROUP_SIZE]);
    end

    if (acc) begin
      case (in_item.action)
        ACT_COLLECT: begin
          if (!active_r && !hit && (distinct_r < 8'(ALPHABET_MAX))) begin
            seen_nxt[in_item.data_byte] = 1'b1;
            distinct_nxt                = distinct_r + 8'd1;
          end
        end
        ACT_START: begin
          width_nxt     = width_for(distinct_r);
          pad_nxt       = 3'd0 - total_lo;
          active_nxt    = 1'b1;
          wr_en         = 1'b1;
          wr_data.kind  = KIND_START;
          wr_data.width = width_nxt;
          wr_data.pad   = pad_nxt;
        end
        ACT_ENCODE: begin
          if (active_r) begin
            wr_en        = 1'b1;
            wr_data.kind = hit ? KIND_ENCODE : KIND_MISS;
          end
        end
        ACT_FLUSH: begin
          if (active_r && (pad_r != 3'd0)) begin
            wr_en        = 1'b1;
            wr_data.kind = KIND_FLUSH;
          end
          active_nxt = 1'b0;
        end
        ACT_CLEAR: begin
          seen_nxt     = '0;
          distinct_nxt = '0;
          active_nxt   = 1'b0;
          width_nxt    = '0;
          pad_nxt      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      distinct_r <= '0;
      active_r   <= 1'b0;
      width_r    <= '0;
      pad_r      <= '0;
    end else begin
      seen_r     <= seen_nxt;
      distinct_r <= distinct_nxt;
      active_r   <= active_nxt;
      width_r    <= width_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/arp_queue.sv
// ----------------------------------------------------------------------------
// arp_queue
// two-entry queue of work items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                wr_en,
  input  arp_pkg::arp_work_t wr_data,
  output logic               full,
  input  wire                rd_en,
  output arp_pkg::arp_work_t rd_data,
  output logic               valid
);
  import arp_pkg::*;

  arp_work_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/arp_back.sv
// ----------------------------------------------------------------------------
// arp_back
// sums the rank, packs codes msb-first into the pending byte and drives the
// result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  arp_pkg::arp_work_t q_data,
  output logic               q_pop,
  output logic               empty,
  input  wire                pop,
  output arp_pkg::arp_out_t  out_item
);
  import arp_pkg::*;

  logic [7:0]  pend_r, pend_nxt;
  logic [2:0]  off_r, off_nxt;
  arp_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        advance;
  logic [5:0]  sum1 [8];
  logic [6:0]  sum2 [4];
  logic [7:0]  sum3 [2];
  logic [7:0]  rank;
  logic [15:0] code_wide;
  logic [7:0]  code;
  logic [15:0] carry_wide;
  logic [7:0]  merged;
  logic [3:0]  off_sum;
  logic        fills;

  assign advance  = q_valid && (!out_valid_r || pop);
  assign q_pop    = advance;
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  // rank adder tree
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum1[i] = 6'(q_data.gcnt[2*i]) + 6'(q_data.gcnt[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      sum2[i] = 7'(sum1[2*i]) + 7'(sum1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      sum3[i] = 8'(sum2[2*i]) + 8'(sum2[2*i+1]);
    end
    rank = sum3[0] + sum3[1];
  end

  always_comb begin
    code_wide  = {rank, 8'h00} >> q_data.width;
    code       = code_wide[7:0];
    carry_wide = {code, 8'h00} >> off_r;
    merged     = pend_r | (code >> off_r);
    off_sum    = {1'b0, off_r} + {1'b0, q_data.width};
    fills      = (q_data.width != 3'd0) && off_sum[3];

    pend_nxt      = pend_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && !pop;

    out_nxt.packed_byte    = 8'h00;
    out_nxt.distinct_count = q_data.distinct;
    out_nxt.code_width     = q_data.width;
    out_nxt.not_found      = 1'b0;
    out_nxt.is_status      = 1'b0;

    if (advance) begin
      case (q_data.kind)
        KIND_START: begin
          pend_nxt          = {q_data.pad, 5'b00000};
          off_nxt           = 3'(PAD_BITS);
          out_nxt.is_status = 1'b1;
          out_valid_nxt     = 1'b1;
        end
        KIND_ENCODE: begin
          off_nxt = off_sum[2:0];
          if (fills) begin
            pend_nxt            = carry_wide[7:0];
            out_nxt.packed_byte = merged;
            out_valid_nxt       = 1'b1;
          end else begin
            pend_nxt = merged;
          end
        end
        KIND_MISS: begin
          out_nxt.not_found = 1'b1;
          out_valid_nxt     = 1'b1;
        end
        KIND_FLUSH: begin
          out_nxt.packed_byte = pend_r;
          pend_nxt            = 8'h00;
          off_nxt             = 3'(PAD_BITS);
          out_valid_nxt       = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      off_r       <= 3'(PAD_BITS);
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/alphabet_rank_bit_packer_core.sv
// ----------------------------------------------------------------------------
// alphabet_rank_bit_packer_core
// packs bytes as fixed-width alphabet ranks into an msb-first byte stream
// ----------------------------------------------------------------------------
// input queue side: in_item carries action and data_byte; an item is taken
// when push is high and full is low. collect builds the seen map, start
// latches the code width and pad and returns a status item, encode packs the
// byte's rank or flags a miss, flush returns the last partial byte, clear
// drops all state. result queue side: out_item holds the oldest result while
// empty is low and is taken when pop is high.
// cfg_we/cfg_data write the stream length used for the pad count; write it
// only while no items are in flight.
// an item's work entry passes through the two-entry queue and then the
// result register before its result shows on out_item.
// throughput: one item per cycle while full is low; the front classifies and
// counts the rank per group, a two-entry queue feeds the back end, which sums
// and packs. when the receiver stalls the output register holds, the queue
// fills and full rises after two more work items. reset (rst_n low,
// synchronous) empties both queues, clears the seen map and the stream length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alphabet_rank_bit_packer_core #(
  parameter int ALPHABET_MAX = arp_pkg::ALPHABET_MAX_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  output logic                     full,
  input  arp_pkg::arp_in_t         in_item,
  output logic                     empty,
  input  wire                      pop,
  output arp_pkg::arp_out_t        out_item,
  input  wire                      cfg_we,
  input  wire [arp_pkg::LEN_W-1:0] cfg_data
);
  import arp_pkg::*;

  logic      acc;
  logic      wr_en;
  arp_work_t wr_data;
  logic      q_valid;
  logic      q_pop;
  arp_work_t q_data;

  assign acc = push && !full;

  arp_front #(
    .ALPHABET_MAX(ALPHABET_MAX)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_item (in_item),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  arp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .valid  (q_valid)
  );

  arp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule

`default_nettype wire

### rtl/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// port-level checks of the alphabet rank bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_checker #(
  parameter int ALPHABET_MAX = arp_pkg::ALPHABET_MAX_DEF
) (
  input wire               clk,
  input wire               rst_n,
  input wire               empty,
  input wire               pop,
  input arp_pkg::arp_out_t out_item
);
  import arp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled item changed");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.is_status) |->
      (out_item.packed_byte == 8'h00 && !out_item.not_found))
    else $error("status item carries data");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.not_found) |->
      (out_item.packed_byte == 8'h00 && !out_item.is_status))
    else $error("miss item carries data");

  a_width_match: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.code_width == width_for(out_item.distinct_count) &&
                out_item.distinct_count <= 8'(ALPHABET_MAX)))
    else $error("code width does not fit distinct count");

endmodule

bind alphabet_rank_bit_packer_core arp_checker #(
  .ALPHABET_MAX(ALPHABET_MAX)
) u_arp_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_item(out_item)
);

`default_nettype wire
